@@ design/blgh_pkg.sv @@
// Shared types, register codes and threshold constants for the battery level gauge.
// No dependencies; the top level refers to these by scoped names.
package blgh_pkg;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_FORCE_READING = 2'd0;
   localparam logic [1:0] REG_EMPTY_MARK    = 2'd1;
   localparam logic [1:0] REG_GOOD_MARK     = 2'd2;

   localparam logic [11:0] EMPTY_MARK_RESET = 12'd1145;
   localparam logic [11:0] GOOD_MARK_RESET  = 12'd1550;

   // Charge timer actions.
   localparam logic [1:0] ACT_KEEP  = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_CLAMP = 2'd2;

   // Offset thresholds above the empty mark.
   localparam logic [11:0] OFF_FULL       = 12'd422;
   localparam logic [11:0] OFF_NEAR_FULL  = 12'd350;
   localparam logic [11:0] OFF_RISE_SIX   = 12'd355;
   localparam logic [11:0] OFF_HOLD_SIX   = 12'd396;
   localparam logic [11:0] OFF_CLAMP      = 12'd395;
   localparam logic [15:0] CHARGE_CLAMP_S = 16'd600;
   localparam logic [11:0] OFF_BAND5      = 12'd325;
   localparam logic [11:0] OFF_BAND4      = 12'd260;
   localparam logic [11:0] OFF_BAND3      = 12'd200;
   localparam logic [11:0] OFF_BAND2      = 12'd100;
   localparam logic [11:0] DOWN_BAND5     = 12'd365;
   localparam logic [11:0] DOWN_BAND4     = 12'd320;
   localparam logic [11:0] DOWN_BAND3     = 12'd260;
   localparam logic [11:0] DOWN_BAND2     = 12'd190;
   localparam logic [11:0] DOWN_BAND1     = 12'd90;

   localparam logic [2:0] LEVEL_EMPTY = 3'd0;
   localparam logic [2:0] LEVEL_SIX   = 3'd6;
   localparam logic [2:0] LEVEL_FULL  = 3'd7;

   localparam logic [3:0] CONFIRM_COUNT_MAX = 4'd10;
   localparam logic [3:0] WARN_BLINK_COUNT  = 4'd10;
   localparam logic [3:0] WARN_COUNT_MAX    = 4'd11;

   typedef struct packed {
      logic [11:0] reading;
      logic        output_active;
      logic [15:0] charge_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] level;
      logic       start_blink;
      logic       clear_full_count;
      logic [1:0] charge_time_action;
   } rsp_payload_type;

endpackage

@@ design/battery_level_gauge_hysteresis.sv @@
// Battery level gauge with hysteresis: input register, band logic, result register.
// Depends on blgh_pkg for payload types, register codes and thresholds.
// A request is held in the input register, then its result in the result register.
// One request per cycle unless rsp_ready stalls; level and counters take one compare pass.
// Reset (synchronous, active high) clears level and counters, restores register defaults.
module battery_level_gauge_hysteresis (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  blgh_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output blgh_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic                      force_reading_ff;
   logic [11:0]               empty_mark_ff;
   logic [11:0]               good_mark_ff;
   logic [2:0]                level_ff, level_in;
   logic [3:0]                confirm_ff, confirm_in;
   logic [3:0]                warn_ff, warn_in;
   logic                      stage_valid_ff;
   blgh_pkg::req_payload_type stage_ff;
   logic                      rsp_valid_ff;
   blgh_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                      out_free;
   logic                      advance;
   logic                      cfg_write;

   logic [11:0] rd;
   logic [11:0] off;
   logic [3:0]  confirm_inc;
   logic [3:0]  warn_inc;
   logic        low_pending;
   logic        confirmed_low;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[3:2])
         blgh_pkg::REG_FORCE_READING: prdata = {31'd0, force_reading_ff};
         blgh_pkg::REG_EMPTY_MARK:    prdata = {20'd0, empty_mark_ff};
         blgh_pkg::REG_GOOD_MARK:     prdata = {20'd0, good_mark_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_reading_ff <= 1'b0;
         empty_mark_ff    <= blgh_pkg::EMPTY_MARK_RESET;
         good_mark_ff     <= blgh_pkg::GOOD_MARK_RESET;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            blgh_pkg::REG_FORCE_READING: force_reading_ff <= pwdata[0];
            blgh_pkg::REG_EMPTY_MARK:    empty_mark_ff    <= pwdata[11:0];
            blgh_pkg::REG_GOOD_MARK:     good_mark_ff     <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   // The input stage empties whenever the result register can take its request.
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign advance   = stage_valid_ff & out_free;
   assign req_ready = ~stage_valid_ff | out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      rd = force_reading_ff ? good_mark_ff : stage_ff.reading;
      confirm_inc = (confirm_ff >= blgh_pkg::CONFIRM_COUNT_MAX) ?
                    blgh_pkg::CONFIRM_COUNT_MAX : confirm_ff + 4'd1;
      warn_inc = (warn_ff >= blgh_pkg::WARN_COUNT_MAX) ?
                 blgh_pkg::WARN_COUNT_MAX : warn_ff + 4'd1;
      low_pending   = 1'b0;
      confirmed_low = 1'b0;
      confirm_in = confirm_ff;
      warn_in    = warn_ff;
      level_in   = level_ff;
      rsp_in.start_blink        = 1'b0;
      rsp_in.clear_full_count   = 1'b0;
      rsp_in.charge_time_action = blgh_pkg::ACT_KEEP;

      priority if (rd > good_mark_ff) begin
         confirm_in = 4'd0;
      end else if (rd < empty_mark_ff) begin
         confirm_in = confirm_inc;
         if (confirm_inc < blgh_pkg::CONFIRM_COUNT_MAX) begin
            low_pending = 1'b1;
         end else begin
            confirmed_low = 1'b1;
            level_in      = blgh_pkg::LEVEL_EMPTY;
            if (stage_ff.output_active) begin
               warn_in = warn_inc;
               rsp_in.start_blink = (warn_ff == blgh_pkg::WARN_BLINK_COUNT - 4'd1);
            end
         end
      end else begin
         confirm_in = 4'd0;
         warn_in    = 4'd0;
      end

      // A confirmed low reading counts as sitting on the empty mark: offset zero.
      off = (!confirmed_low && rd >= empty_mark_ff) ? rd - empty_mark_ff : 12'd0;

      if (!low_pending) begin
         priority if (off >= blgh_pkg::OFF_FULL) begin
            level_in = blgh_pkg::LEVEL_FULL;
         end else if (off > blgh_pkg::OFF_NEAR_FULL) begin
            rsp_in.clear_full_count = 1'b1;
            if (level_ff < blgh_pkg::LEVEL_SIX) begin
               if (off > blgh_pkg::OFF_RISE_SIX) level_in = blgh_pkg::LEVEL_SIX;
            end else if (stage_ff.charge_seconds == 16'd0 && off < blgh_pkg::OFF_HOLD_SIX) begin
               level_in = blgh_pkg::LEVEL_SIX;
            end
            if (stage_ff.charge_seconds > blgh_pkg::CHARGE_CLAMP_S &&
                off > blgh_pkg::OFF_CLAMP) begin
               rsp_in.charge_time_action = blgh_pkg::ACT_CLAMP;
               level_in = blgh_pkg::LEVEL_FULL;
            end
         end else if (off > blgh_pkg::OFF_BAND5) begin
            rsp_in.charge_time_action = blgh_pkg::ACT_CLEAR;
            if (level_ff <= 3'd5 || off < blgh_pkg::DOWN_BAND5) level_in = 3'd5;
         end else if (off > blgh_pkg::OFF_BAND4) begin
            rsp_in.charge_time_action = blgh_pkg::ACT_CLEAR;
            if (level_ff <= 3'd4 || off < blgh_pkg::DOWN_BAND4) level_in = 3'd4;
         end else if (off > blgh_pkg::OFF_BAND3) begin
            rsp_in.charge_time_action = blgh_pkg::ACT_CLEAR;
            if (level_ff <= 3'd3 || off < blgh_pkg::DOWN_BAND3) level_in = 3'd3;
         end else if (off > blgh_pkg::OFF_BAND2) begin
            rsp_in.charge_time_action = blgh_pkg::ACT_CLEAR;
            if (level_ff <= 3'd2 || off < blgh_pkg::DOWN_BAND2) level_in = 3'd2;
         end else if (off > 12'd0) begin
            rsp_in.charge_time_action = blgh_pkg::ACT_CLEAR;
            if (level_ff <= 3'd1 || off < blgh_pkg::DOWN_BAND1) level_in = 3'd1;
         end else begin
            // An offset of zero selects no band, so the level is left alone.
         end
      end

      rsp_in.level = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         level_ff       <= 3'd0;
         confirm_ff     <= 4'd0;
         warn_ff        <= 4'd0;
      end else begin
         if (req_ready) stage_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            level_ff     <= level_in;
            confirm_ff   <= confirm_in;
            warn_ff      <= warn_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) stage_ff <= req_payload;
      if (advance) rsp_ff <= rsp_in;
   end

   a_counters_bounded: assert property (@(posedge clock) disable iff (reset)
      confirm_ff <= blgh_pkg::CONFIRM_COUNT_MAX && warn_ff <= blgh_pkg::WARN_COUNT_MAX)
      else $error("low counters exceeded their saturation values");

   a_blink_at_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_blink |->
         rsp_ff.level == blgh_pkg::LEVEL_EMPTY &&
         rsp_ff.charge_time_action == blgh_pkg::ACT_KEEP)
      else $error("blink request raised while level is not empty");

   a_near_full_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.clear_full_count |->
         rsp_ff.charge_time_action != blgh_pkg::ACT_CLEAR)
      else $error("near-full band gave a timer clear action");

   a_level_tracks_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ff.level == level_ff)
      else $error("stored level differs from the level just delivered");

endmodule
